FILE: hdl/sss_pkg.sv
// sss_pkg: shared types, codes and the segment lookup for the seven-segment
// scan serializer. No dependencies; imported by the top level and its checker.

package sss_pkg;

  // field widths
  localparam int unsigned OpW        = 2;
  localparam int unsigned CodeW      = 5;
  localparam int unsigned NumW       = 8;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned RunBits    = 2 * BitsPerByte;
  localparam int unsigned RunCntW    = $clog2(RunBits + 1);

  // operation codes
  localparam logic [OpW-1:0] OP_TICK   = 2'd0;
  localparam logic [OpW-1:0] OP_SET4   = 2'd1;
  localparam logic [OpW-1:0] OP_SETNUM = 2'd2;

  // character codes
  localparam logic [CodeW-1:0] CODE_BLANK = 5'd11;
  localparam logic [CodeW-1:0] CODE_LAST  = 5'd16;
  localparam logic [BitsPerByte-1:0] SEG_BLANK   = 8'hFF;
  localparam logic [BitsPerByte-1:0] POS_TOP_BIT = 8'h80;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [BitsPerByte-1:0] seg_t;

  // active-low segment byte for a character code, blank above the last code
  function automatic seg_t seg_of(input code_t code);
    seg_t seg;
    unique case (code)
      5'd0:    seg = 8'h03;
      5'd1:    seg = 8'h9F;
      5'd2:    seg = 8'h25;
      5'd3:    seg = 8'h0D;
      5'd4:    seg = 8'h99;
      5'd5:    seg = 8'h49;
      5'd6:    seg = 8'h41;
      5'd7:    seg = 8'h1F;
      5'd8:    seg = 8'h01;
      5'd9:    seg = 8'h09;
      5'd10:   seg = 8'hFD;
      5'd11:   seg = 8'hFF;
      5'd12:   seg = 8'h11;
      5'd13:   seg = 8'h91;
      5'd14:   seg = 8'h49;
      5'd15:   seg = 8'h71;
      5'd16:   seg = 8'h61;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

FILE: hdl/seven_segment_scan_serializer.sv
// seven_segment_scan_serializer: top level, input register, code store and
// sixteen-bit output serializer. Depends on sss_pkg.

// A refresh tick produces one run of sixteen serial bits, one per cycle at
// best, LSB first: the active-low segment byte of the current digit followed
// by the one-hot position byte; latch_after_o marks the last bit of the run.
// Set operations (four codes, or a lead code plus a number in decimal)
// produce no output. Input items pass through one input register; set
// operations flow at one per cycle unless a tick ahead of them waits, and a
// tick waits in that register until the output shift register can take its
// run, so the serializer takes no new tick before the current run's final
// transfer; it loads the next run in the same cycle as that final transfer.
module seven_segment_scan_serializer #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [sss_pkg::OpW-1:0]  operation_i,
  input  logic [sss_pkg::CodeW-1:0] code0_i,
  input  logic [sss_pkg::CodeW-1:0] code1_i,
  input  logic [sss_pkg::CodeW-1:0] code2_i,
  input  logic [sss_pkg::CodeW-1:0] code3_i,
  input  logic [sss_pkg::NumW-1:0] number_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     serial_bit_o,
  output logic                     latch_after_o,
  output logic [1:0]               scan_digit_o
);
  import sss_pkg::*;

  localparam int unsigned PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  // input register
  logic               s1_valid_q;
  logic [OpW-1:0]     s1_op_q;
  code_t              s1_c0_q, s1_c1_q, s1_c2_q, s1_c3_q;
  logic [NumW-1:0]    s1_num_q;
  logic               s1_advance;

  // digit state
  code_t              codes_q [4];
  logic [PosW-1:0]    pos_q;

  // serializer
  logic [RunBits-1:0] word_q;
  logic [RunCntW-1:0] cnt_q;
  logic [1:0]         run_pos_q;
  logic               out_xfer;
  logic               ser_free;
  logic               load;

  assign out_xfer   = out_valid_o && out_ready_i;
  assign ser_free   = (cnt_q == '0) || ((cnt_q == RunCntW'(1)) && out_ready_i);
  assign s1_advance = s1_valid_q && ((s1_op_q != OP_TICK) || ser_free);
  assign load       = s1_valid_q && (s1_op_q == OP_TICK) && ser_free;
  assign in_ready_o = !s1_valid_q || s1_advance;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q  <= operation_i;
      s1_c0_q  <= code0_i;
      s1_c1_q  <= code1_i;
      s1_c2_q  <= code2_i;
      s1_c3_q  <= code3_i;
      s1_num_q <= number_i;
    end
  end

  // decimal split of the number by reciprocal multiplication
  logic [15:0] prod_tens;
  logic [15:0] prod_hund;
  logic [4:0]  rest;
  logic [1:0]  hund;
  logic [7:0]  rest_x10;
  logic [4:0]  hund_x10;
  logic [3:0]  ones;
  logic [3:0]  tens;

  always_comb begin
    prod_tens = 16'(s1_num_q) * 16'd205;
    prod_hund = 16'(s1_num_q) * 16'd41;
    rest      = prod_tens[15:11];
    hund      = prod_hund[13:12];
    rest_x10  = 8'(rest) * 8'd10;
    hund_x10  = 5'(hund) * 5'd10;
    ones      = 4'(s1_num_q - rest_x10);
    tens      = 4'(rest - hund_x10);
  end

  // run word for the current position
  logic [2:0]          pos_ext;
  logic [3:0]          pos_inc;
  code_t               cur_code;
  seg_t                cur_seg;
  seg_t                onehot;
  logic [PosW-1:0]     pos_next;

  always_comb begin
    pos_ext  = 3'(pos_q);
    pos_inc  = 4'(pos_ext) + 4'd1;
    cur_code = (pos_ext < 3'd4) ? codes_q[pos_ext[1:0]] : CODE_BLANK;
    cur_seg  = seg_of(cur_code);
    onehot   = POS_TOP_BIT >> pos_ext;
    pos_next = (pos_inc >= 4'(DIGIT_COUNT)) ? '0 : PosW'(pos_inc);
  end

  // code store and scan position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q[0] <= 5'd8;
      codes_q[1] <= 5'd9;
      codes_q[2] <= 5'd10;
      codes_q[3] <= CODE_BLANK;
      pos_q      <= '0;
    end else if (s1_advance) begin
      priority if (s1_op_q == OP_SET4) begin
        codes_q[0] <= s1_c0_q;
        codes_q[1] <= s1_c1_q;
        codes_q[2] <= s1_c2_q;
        codes_q[3] <= s1_c3_q;
      end else if (s1_op_q == OP_SETNUM) begin
        codes_q[0] <= s1_c0_q;
        codes_q[3] <= CodeW'(ones);
        if (rest != '0) begin
          codes_q[2] <= CodeW'(tens);
          codes_q[1] <= (hund != '0) ? CodeW'(hund) : CODE_BLANK;
        end else begin
          codes_q[2] <= CODE_BLANK;
          codes_q[1] <= CODE_BLANK;
        end
      end else if (s1_op_q == OP_TICK) begin
        pos_q <= pos_next;
      end else begin
        pos_q <= pos_q;
      end
    end
  end

  // serializer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= RunCntW'(RunBits);
    end else if (out_xfer) begin
      cnt_q <= cnt_q - RunCntW'(1);
    end
  end

  // serializer data, shifted right on each transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q    <= {onehot, cur_seg};
      run_pos_q <= pos_ext[1:0];
    end else if (out_xfer) begin
      word_q    <= word_q >> 1;
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign serial_bit_o  = word_q[0];
  assign latch_after_o = (cnt_q == RunCntW'(1));
  assign scan_digit_o  = run_pos_q;

endmodule

FILE: hdl/sss_checker.sv
// sss_checker: port-level assertions for the seven-segment scan serializer,
// bound to the top level below. Depends on sss_pkg, which it imports.

module sss_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      serial_bit_o,
  input logic                      latch_after_o,
  input logic [1:0]                scan_digit_o
);
  import sss_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid_o && out_ready_i;

  // a stalled output holds its bit, marker and digit
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(serial_bit_o) && $stable(latch_after_o)
      && $stable(scan_digit_o))
    else $error("output changed while stalled");

  // a run continues without a gap until its latch bit
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !latch_after_o |=> out_valid_o)
    else $error("run broke before latch bit");

  // the digit stays fixed within a run
  a_run_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !latch_after_o |=> $stable(scan_digit_o))
    else $error("scan digit changed within a run");

  // the bit after a latch opens a new run, never another latch
  a_latch_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && latch_after_o |=> !latch_after_o)
    else $error("latch bit repeated");

endmodule

bind seven_segment_scan_serializer sss_checker u_sss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .serial_bit_o  (serial_bit_o),
  .latch_after_o (latch_after_o),
  .scan_digit_o  (scan_digit_o)
);
